// ===== rtl/alsp_pkg.sv =====
// Shared types, phase codes and constants of the audit log stream parser.
package alsp_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT  = 1'd1;

    localparam logic [31:0] SEGMENT_LIMIT_RST = 32'd1000000;
    localparam logic [15:0] RECORD_LIMIT_RST  = 16'd4096;

    // Parse phases; the field phases double as the field_kind codes
    localparam logic [3:0] PH_SEGCOUNT = 4'd0;
    localparam logic [3:0] PH_SEGSEQ   = 4'd1;
    localparam logic [3:0] PH_PREVHASH = 4'd2;
    localparam logic [3:0] PH_SEGHASH  = 4'd3;
    localparam logic [3:0] PH_RECCOUNT = 4'd4;
    localparam logic [3:0] PH_RECSEQ   = 4'd5;
    localparam logic [3:0] PH_TIME     = 4'd6;
    localparam logic [3:0] PH_REASON   = 4'd7;
    localparam logic [3:0] PH_EVIDENCE = 4'd8;
    localparam logic [3:0] PH_CORR     = 4'd9;
    localparam logic [3:0] PH_MAGIC    = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;

    localparam logic [3:0] DIGEST_WORDS = 4'd4;
    localparam logic [3:0] CORR_WORDS   = 4'd9;

    // "AISHAD02"
    localparam logic [7:0] MAGIC_BYTES [8] = '{
        8'h41, 8'h49, 8'h53, 8'h48, 8'h41, 8'h44, 8'h30, 8'h32
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte_item;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [3:0]  word_index;
        logic [63:0] word_value;
        logic        verdict;
        logic        status;
    } t_result;

endpackage

// ===== rtl/alsp_if.sv =====
// Valid/ready stream interfaces for the byte input and the field result channels.
interface alsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface alsp_field_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_kind;
    logic [3:0]  word_index;
    logic [63:0] word_value;
    logic        verdict;
    logic        status;

    modport source (output valid, output field_kind, output word_index,
                    output word_value, output verdict, output status, input ready);
    modport sink   (input valid, input field_kind, input word_index,
                    input word_value, input verdict, input status, output ready);
endinterface

// ===== rtl/audit_log_stream_parser_unit.sv =====
// Audit log stream parser: byte-serial log parser with field and verdict results.
// Usage:
//   i_byte carries one log byte per transfer, last_byte set on the buffer's final byte.
//   o_field carries results: every finished field word (64-bit, the reason word 32-bit; digest and correlation
//   words with their word_index) and one verdict per buffer (verdict = 1, status 1 on
//   malformed input). A word that finishes on a verdict byte rides on the verdict.
//   Many bytes produce no result at all.
//   Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write segment_limit (index 0)
//   and record_limit (index 1); write only while the parser is idle.
// Timing:
//   One byte per cycle sustained while o_field is not stalled. A byte is parsed while it sits
//   in the input register, and its result is loaded into the result register that drives
//   o_field. The single step of the parse state (byte lane insert, limit compare, counter
//   decrement) sets the rate.
// Reset:
//   i_rst_n low (synchronous) empties both registers, restarts at the magic check and
//   loads the default limits (1000000 segments, 4096 records).
// Back-pressure:
//   While o_field is stalled the result register holds; an empty input register takes
//   one more byte, then i_byte.ready drops until the result drains.
module audit_log_stream_parser_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    alsp_byte_if.sink                        i_byte,
    alsp_field_if.source                     o_field,
    input  logic                             i_cfg_we,
    input  logic [alsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [alsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import alsp_pkg::*;

    logic [31:0] r_seg_limit;
    logic [15:0] r_rec_limit;

    logic       w_in_valid;
    t_byte_item w_item;
    logic       w_out_free;
    logic       w_fire;
    logic       w_res_valid;
    t_result    w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_limit <= SEGMENT_LIMIT_RST;
            r_rec_limit <= RECORD_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEGMENT_LIMIT: r_seg_limit <= i_cfg_data[31:0];
                REG_RECORD_LIMIT:  r_rec_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Advance a byte whenever the result register can take what it produces
    assign w_fire = w_in_valid && w_out_free;

    alsp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_pop   (w_fire),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    alsp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .i_seg_limit (r_seg_limit),
        .i_rec_limit (r_rec_limit),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    alsp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_field (o_field)
    );

`ifndef NO_ASSERTIONS
    // A plain field result never carries a malformed status
    a_status_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_field.valid && !o_field.verdict) |-> !o_field.status)
        else $error("status set on a non-verdict result");

    // Only digest and correlation words carry a word index
    a_index_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_field.valid && (o_field.word_index != 4'd0)) |->
        ((o_field.field_kind == PH_PREVHASH) || (o_field.field_kind == PH_SEGHASH) ||
         (o_field.field_kind == PH_EVIDENCE) || (o_field.field_kind == PH_CORR)))
        else $error("word index on a scalar field");

    // Full input register behind a stalled result blocks the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_field.valid && !o_field.ready && w_in_valid) |-> !i_byte.ready)
        else $error("input accepted while both registers are full");
`endif
endmodule

// ===== rtl/alsp_in_reg.sv =====
// Input register of the parser: holds one byte transfer until the step logic takes it.
module alsp_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    alsp_byte_if.sink           i_byte,
    input  logic                i_pop,
    output logic                o_valid,
    output alsp_pkg::t_byte_item o_item
);
    import alsp_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_byte_item r_item;
    logic       w_take;

    assign i_byte.ready = !r_valid || i_pop;
    assign w_take       = i_byte.valid && i_byte.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.data_byte <= i_byte.data_byte;
            r_item.last_byte <= i_byte.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== rtl/alsp_step.sv =====
// Parse state and the single-pass step logic that turns one byte into at most one result.
module alsp_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  alsp_pkg::t_byte_item i_item,
    input  logic [31:0]          i_seg_limit,
    input  logic [15:0]          i_rec_limit,
    output logic                 o_res_valid,
    output alsp_pkg::t_result    o_res
);
    import alsp_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_bif, n_bif;
    logic [3:0]  r_wcnt, n_wcnt;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_segs, n_segs;
    logic [15:0] r_recs, n_recs;
    logic        r_drop, n_drop;

    logic [63:0] w_word;
    logic [31:0] w_segs_dec;
    logic [15:0] w_recs_dec;
    logic [3:0]  w_wnext;
    logic        w_done_word;
    logic        w_err;
    logic        w_emit;
    logic        w_last;

    assign w_segs_dec = r_segs - 32'd1;
    assign w_recs_dec = r_recs - 16'd1;
    assign w_wnext    = r_wcnt + 4'd1;
    assign w_last     = i_item.last_byte;

    always_comb begin
        w_word = r_acc;
        w_word[{r_bif, 3'b000} +: 8] = i_item.data_byte;
    end

    assign w_done_word = (r_phase == PH_REASON) ? (r_bif == 3'd3) : (r_bif == 3'd7);

    always_comb begin
        n_phase     = r_phase;
        n_bif       = r_bif;
        n_wcnt      = r_wcnt;
        n_acc       = r_acc;
        n_segs      = r_segs;
        n_recs      = r_recs;
        n_drop      = r_drop;
        w_err       = 1'b0;
        w_emit      = 1'b0;
        o_res       = '0;
        o_res_valid = 1'b0;

        if (r_drop) begin
            // drop bytes until the buffer ends
            if (w_last) begin
                n_drop  = 1'b0;
                n_phase = PH_MAGIC;
                n_bif   = 3'd0;
                n_wcnt  = 4'd0;
                n_acc   = '0;
                n_segs  = '0;
                n_recs  = '0;
            end
        end else begin
            if (r_phase == PH_MAGIC) begin
                if (i_item.data_byte != MAGIC_BYTES[r_bif]) begin
                    w_err = 1'b1;
                end else if (r_bif == 3'd7) begin
                    n_bif   = 3'd0;
                    n_acc   = '0;
                    n_phase = PH_SEGCOUNT;
                end else begin
                    n_bif = r_bif + 3'd1;
                end
            end else if (r_phase >= PH_DONE) begin
                w_err = 1'b1;
            end else if (!w_done_word) begin
                n_bif = r_bif + 3'd1;
                n_acc = w_word;
            end else begin
                w_emit               = 1'b1;
                o_res.field_kind     = r_phase;
                o_res.word_value     = w_word;
                n_acc                = '0;
                n_bif                = 3'd0;
                case (r_phase)
                    PH_PREVHASH, PH_SEGHASH, PH_EVIDENCE, PH_CORR: begin
                        o_res.word_index = r_wcnt;
                    end
                    default: begin
                        o_res.word_index = 4'd0;
                    end
                endcase
                case (r_phase)
                    PH_SEGCOUNT: begin
                        if (w_word > {32'd0, i_seg_limit}) begin
                            w_err = 1'b1;
                        end else begin
                            n_segs  = w_word[31:0];
                            n_phase = (w_word[31:0] != 32'd0) ? PH_SEGSEQ : PH_DONE;
                        end
                    end
                    PH_SEGSEQ: begin
                        n_phase = PH_PREVHASH;
                        n_wcnt  = 4'd0;
                    end
                    PH_PREVHASH, PH_SEGHASH, PH_EVIDENCE: begin
                        n_wcnt = w_wnext;
                        if (w_wnext >= DIGEST_WORDS) begin
                            n_wcnt = 4'd0;
                            case (r_phase)
                                PH_PREVHASH: n_phase = PH_SEGHASH;
                                PH_SEGHASH:  n_phase = PH_RECCOUNT;
                                default:     n_phase = PH_CORR;
                            endcase
                        end
                    end
                    PH_RECCOUNT: begin
                        if (w_word > {48'd0, i_rec_limit}) begin
                            w_err = 1'b1;
                        end else begin
                            n_recs = w_word[15:0];
                            if (w_word[15:0] != 16'd0) begin
                                n_phase = PH_RECSEQ;
                            end else begin
                                n_segs  = w_segs_dec;
                                n_phase = (w_segs_dec != 32'd0) ? PH_SEGSEQ : PH_DONE;
                            end
                        end
                    end
                    PH_RECSEQ: begin
                        n_phase = PH_TIME;
                    end
                    PH_TIME: begin
                        n_phase = PH_REASON;
                    end
                    PH_REASON: begin
                        n_phase = PH_EVIDENCE;
                        n_wcnt  = 4'd0;
                    end
                    default: begin
                        // correlation words close the record after the ninth
                        n_wcnt = w_wnext;
                        if (w_wnext >= CORR_WORDS) begin
                            n_wcnt = 4'd0;
                            n_recs = w_recs_dec;
                            if (w_recs_dec != 16'd0) begin
                                n_phase = PH_RECSEQ;
                            end else begin
                                n_segs  = w_segs_dec;
                                n_phase = (w_segs_dec != 32'd0) ? PH_SEGSEQ : PH_DONE;
                            end
                        end
                    end
                endcase
            end

            if (w_err || w_last) begin
                o_res_valid   = 1'b1;
                o_res.verdict = 1'b1;
                o_res.status  = w_err || (n_phase != PH_DONE);
                if (w_err && !w_last) begin
                    n_drop = 1'b1;
                end
                n_phase = PH_MAGIC;
                n_bif   = 3'd0;
                n_wcnt  = 4'd0;
                n_acc   = '0;
                n_segs  = '0;
                n_recs  = '0;
            end else begin
                o_res_valid = w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_bif   <= 3'd0;
            r_wcnt  <= 4'd0;
            r_acc   <= '0;
            r_segs  <= '0;
            r_recs  <= '0;
            r_drop  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_wcnt  <= n_wcnt;
            r_acc   <= n_acc;
            r_segs  <= n_segs;
            r_recs  <= n_recs;
            r_drop  <= n_drop;
        end
    end
endmodule

// ===== rtl/alsp_out_reg.sv =====
// Result register: holds one field result until the receiver takes the transfer.
module alsp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  alsp_pkg::t_result i_res,
    output logic              o_free,
    alsp_field_if.source      o_field
);
    import alsp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || o_field.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_field.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_field.valid      = r_valid;
    assign o_field.field_kind = r_res.field_kind;
    assign o_field.word_index = r_res.word_index;
    assign o_field.word_value = r_res.word_value;
    assign o_field.verdict    = r_res.verdict;
    assign o_field.status     = r_res.status;
endmodule
